@@ src/packet_reorder_buffer_macros.svh @@
// Assertion helpers
`ifndef PACKET_REORDER_BUFFER_MACROS_SVH
`define PACKET_REORDER_BUFFER_MACROS_SVH
`define PRB_ASSERT_IMPL(lbl, rst, a, c) \
  lbl: assert property (@(posedge clk) disable iff (!rst) (a) |-> (c)) else $error("lbl");
`define PRB_ASSERT_NEXT(lbl, rst, a, c) \
  lbl: assert property (@(posedge clk) disable iff (!rst) (a) |=> (c)) else $error("lbl");
`endif

@@ src/prb_pkg.sv @@
package prb_pkg;
  localparam int Depth = 64;
  localparam int IdxW = $clog2(Depth);
  localparam logic [19:0] DefWindow = 20'd150000;
  localparam logic [1:0] RegUseWait = 2'd0;
  localparam logic [1:0] RegDefWin = 2'd1;
  localparam logic [1:0] RegBound = 2'd2;

  typedef enum logic [6:0] {
    ST_IDLE  = 7'b0000001,
    ST_ACC   = 7'b0000010,
    ST_FLUSH = 7'b0000100,
    ST_STORE = 7'b0001000,
    ST_GAP   = 7'b0010000,
    ST_PULL  = 7'b0100000,
    ST_OUT   = 7'b1000000
  } state_t;

  typedef struct packed {
    logic load;
    logic arrive;
    logic flush_step;
    logic store;
    logic gap_step;
    logic pull;
    logic emit;
  } cmd_t;

  typedef struct packed {
    logic action;
    logic need_flush;
    logic flush_done;
    logic need_gap;
    logic gap_done;
  } sts_t;
endpackage

@@ src/prb_ctrl.sv @@
module prb_ctrl (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_tvalid,
  output logic             in_tready,
  output logic             out_tvalid,
  input  logic             out_tready,
  input  prb_pkg::sts_t    sts,
  output prb_pkg::cmd_t    cmd
);
  `include "packet_reorder_buffer_macros.svh"
  prb_pkg::state_t state_r, state_nxt;

  assign in_tready = (state_r == prb_pkg::ST_IDLE);
  assign out_tvalid = (state_r == prb_pkg::ST_OUT);

  always_comb begin
    state_nxt = state_r;
    cmd = '0;
    unique case (state_r)
      prb_pkg::ST_IDLE: begin
        if (in_tvalid) begin
          cmd.load = 1'b1;
          state_nxt = prb_pkg::ST_ACC;
        end
      end
      prb_pkg::ST_ACC: begin
        if (sts.action) begin
          state_nxt = prb_pkg::ST_PULL;
        end else begin
          cmd.arrive = 1'b1;
          state_nxt = sts.need_flush ? prb_pkg::ST_FLUSH : prb_pkg::ST_STORE;
        end
      end
      prb_pkg::ST_FLUSH: begin
        if (sts.flush_done) state_nxt = prb_pkg::ST_STORE;
        else cmd.flush_step = 1'b1;
      end
      prb_pkg::ST_STORE: begin
        cmd.store = 1'b1;
        state_nxt = sts.need_gap ? prb_pkg::ST_GAP : prb_pkg::ST_OUT;
      end
      prb_pkg::ST_GAP: begin
        if (sts.gap_done) state_nxt = prb_pkg::ST_OUT;
        else cmd.gap_step = 1'b1;
      end
      prb_pkg::ST_PULL: begin
        cmd.pull = 1'b1;
        state_nxt = prb_pkg::ST_OUT;
      end
      prb_pkg::ST_OUT: begin
        if (out_tready) begin
          cmd.emit = 1'b1;
          state_nxt = prb_pkg::ST_IDLE;
        end
      end
      default: state_nxt = prb_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= prb_pkg::ST_IDLE;
    else state_r <= state_nxt;
  end

  `PRB_ASSERT_IMPL(a_onehot, rst_n, 1'b1, $onehot(state_r))
  `PRB_ASSERT_NEXT(a_load, rst_n, in_tvalid && in_tready, state_r == prb_pkg::ST_ACC)
  `PRB_ASSERT_IMPL(a_excl, rst_n, 1'b1, !(in_tready && out_tvalid))
endmodule

@@ src/prb_dp.sv @@
module prb_dp (
  input  logic          clk,
  input  logic          rst_n,
  input  prb_pkg::cmd_t cmd,
  output prb_pkg::sts_t sts,
  input  logic [96:0]   in_data,
  input  logic          use_wait,
  input  logic [19:0]   def_win,
  input  logic [19:0]   bound,
  output logic [149:0]  res
);
  localparam int IW = prb_pkg::IdxW;
  localparam int CW = IW + 1;
  logic [prb_pkg::Depth-1:0] used_r, hole_r;
  logic [31:0] seq_mem [prb_pkg::Depth];
  logic [31:0] pay_mem [prb_pkg::Depth];
  logic        act_r;
  logic [31:0] now_r, seq_r, pay_r;
  logic [31:0] next_exp_r, head_r, last_r, wstart_r, lost_r, reord_r;
  logic [19:0] avg_r, wper_r;
  logic        started_r, waiting_r, deliv_r, over_r;
  logic [31:0] oseq_r, opay_r, rseq_r, rpay_r;
  logic [31:0] gap_pos_r;
  logic [CW-1:0] gap_left_r, cnt_r;
  logic [IW-1:0] idx, hidx, stop;
  logic [31:0] interval, gap;
  logic [21:0] sum;
  logic [19:0] avg_new;

  assign idx = seq_r[IW-1:0];
  assign hidx = head_r[IW-1:0];
  assign stop = idx + IW'(1);
  assign interval = started_r ? (now_r - last_r) : {12'd0, def_win};
  assign gap = seq_r - next_exp_r;

  always_comb begin
    logic [33:0] s;
    s = {2'd0, interval} + {14'd0, avg_r} + {13'd0, avg_r, 1'b0};
    sum = s[33:2] > {12'd0, bound} ? {2'd0, bound} : {2'd0, s[21:2]};
    avg_new = sum[19:0];
  end

  assign sts.action = act_r;
  assign sts.need_flush = used_r[idx] && !hole_r[idx] && rseq_r != seq_r;
  assign sts.flush_done = (hidx == stop) || (cnt_r == CW'(prb_pkg::Depth));
  assign sts.need_gap = seq_r > next_exp_r;
  assign sts.gap_done = gap_left_r == '0;
  assign res = {avg_r, reord_r, lost_r, opay_r, oseq_r, over_r, deliv_r};

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      rseq_r <= seq_mem[in_data[33+IW-1:33]];
      rpay_r <= pay_mem[in_data[33+IW-1:33]];
    end else if (cmd.store || cmd.flush_step) begin
      rseq_r <= rseq_r;
    end else begin
      rseq_r <= seq_mem[hidx];
      rpay_r <= pay_mem[hidx];
    end
    if (cmd.store) begin
      seq_mem[idx] <= seq_r;
      pay_mem[idx] <= pay_r;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      act_r <= in_data[0];
      now_r <= in_data[32:1];
      seq_r <= in_data[64:33];
      pay_r <= in_data[96:65];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      used_r <= '0; hole_r <= '0;
      next_exp_r <= '0; head_r <= '0; last_r <= '0; wstart_r <= '0;
      lost_r <= '0; reord_r <= '0; avg_r <= prb_pkg::DefWindow; wper_r <= '0;
      started_r <= 1'b0; waiting_r <= 1'b0; deliv_r <= 1'b0; over_r <= 1'b0;
      oseq_r <= '0; opay_r <= '0; gap_left_r <= '0; gap_pos_r <= '0;
      cnt_r <= '0;
    end else begin
      if (cmd.load) begin
        deliv_r <= 1'b0; over_r <= 1'b0; oseq_r <= '0; opay_r <= '0;
        cnt_r <= '0;
      end
      if (cmd.arrive) begin
        last_r <= now_r;
        started_r <= 1'b1;
        avg_r <= avg_new;
        over_r <= sts.need_flush;
      end
      if (cmd.flush_step) begin
        used_r[hidx] <= 1'b0; hole_r[hidx] <= 1'b0;
        head_r <= head_r + 32'd1;
        cnt_r <= cnt_r + CW'(1);
      end
      if (cmd.store) begin
        used_r[idx] <= 1'b1; hole_r[idx] <= 1'b0;
        gap_pos_r <= next_exp_r;
        gap_left_r <= (gap >= 32'(prb_pkg::Depth)) ? CW'(prb_pkg::Depth) : gap[CW-1:0];
        if (seq_r > next_exp_r) begin
          next_exp_r <= seq_r + 32'd1; reord_r <= reord_r + 32'd1;
        end else if (seq_r < next_exp_r) begin
          reord_r <= reord_r + 32'd1;
        end else begin
          next_exp_r <= next_exp_r + 32'd1;
        end
      end
      if (cmd.gap_step) begin
        used_r[gap_pos_r[IW-1:0]] <= 1'b1; hole_r[gap_pos_r[IW-1:0]] <= 1'b1;
        gap_pos_r <= gap_pos_r + 32'd1;
        gap_left_r <= gap_left_r - CW'(1);
      end
      if (cmd.pull) begin
        if (waiting_r) begin
          if (!used_r[hidx]) begin
            waiting_r <= 1'b0;
          end else if (!hole_r[hidx]) begin
            waiting_r <= 1'b0; deliv_r <= 1'b1; oseq_r <= rseq_r; opay_r <= rpay_r;
            used_r[hidx] <= 1'b0; hole_r[hidx] <= 1'b0; head_r <= head_r + 32'd1;
          end else if ((now_r - wstart_r) >= {12'd0, wper_r}) begin
            used_r[hidx] <= 1'b0; hole_r[hidx] <= 1'b0; head_r <= head_r + 32'd1;
            lost_r <= lost_r + 32'd1; waiting_r <= 1'b0;
          end
        end else if (used_r[hidx]) begin
          if (hole_r[hidx]) begin
            if (use_wait) begin
              waiting_r <= 1'b1; wstart_r <= now_r; wper_r <= avg_r;
            end else begin
              used_r[hidx] <= 1'b0; hole_r[hidx] <= 1'b0; head_r <= head_r + 32'd1;
              lost_r <= lost_r + 32'd1;
            end
          end else begin
            deliv_r <= 1'b1; oseq_r <= rseq_r; opay_r <= rpay_r;
            used_r[hidx] <= 1'b0; hole_r[hidx] <= 1'b0; head_r <= head_r + 32'd1;
          end
        end
      end
    end
  end

  `PRB_ASSERT_IMPL(a_avg_cap, rst_n, cmd.emit && !act_r, avg_r <= bound)
  `PRB_ASSERT_IMPL(a_gap_dep, rst_n, cmd.gap_step, gap_left_r != '0)
endmodule

@@ src/packet_reorder_buffer.sv @@
// Channel  | Dir | Content
// in_      | in  | action, time_now_us, sequence_number, payload_handle
// out_     | out | delivered .. window_estimate_us
// cfg_     | in  | APB registers use_wait_window, default_window_us, window_bound_us
// Arrival without flush or gap steps through ACC, STORE and OUT, a pull through ACC, PULL and OUT;
// OUT holds until out_tready is high. A flush clears slots one at a time from the head, a gap
// marks slots as holes one at a time (up to 64 slots each).
// One item at a time; input is refused until the result transfers.
// Reset is synchronous, active low; slot flags clear at once.
module packet_reorder_buffer (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  input  logic [103:0] in_tdata,  // action, time_now_us, sequence_number, payload_handle
  output logic         out_tvalid,
  input  logic         out_tready,
  output logic [151:0] out_tdata, // delivered, overflowed, out_sequence, out_payload,
                                  // lost_total, reordered_total, window_estimate_us
  input  logic         cfg_psel,
  input  logic         cfg_penable,
  input  logic         cfg_pwrite,
  input  logic [3:0]   cfg_paddr,
  input  logic [31:0]  cfg_pwdata,
  output logic [31:0]  cfg_prdata,
  output logic         cfg_pready
);
  prb_pkg::cmd_t cmd;
  prb_pkg::sts_t sts;
  logic        use_wait_r;
  logic [19:0] def_win_r, bound_r;
  logic [149:0] res;
  logic [1:0] ridx;

  assign cfg_pready = 1'b1;
  assign ridx = cfg_paddr[3:2];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      use_wait_r <= 1'b1;
      def_win_r <= prb_pkg::DefWindow;
      bound_r <= prb_pkg::DefWindow;
    end else if (cfg_psel && cfg_penable && cfg_pwrite) begin
      unique case (ridx)
        prb_pkg::RegUseWait: use_wait_r <= cfg_pwdata[0];
        prb_pkg::RegDefWin:  def_win_r <= cfg_pwdata[19:0];
        prb_pkg::RegBound:   bound_r <= cfg_pwdata[19:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (ridx)
      prb_pkg::RegUseWait: cfg_prdata = {31'd0, use_wait_r};
      prb_pkg::RegDefWin:  cfg_prdata = {12'd0, def_win_r};
      prb_pkg::RegBound:   cfg_prdata = {12'd0, bound_r};
      default: cfg_prdata = '0;
    endcase
  end

  assign out_tdata = {2'd0, res};

  prb_ctrl u_ctrl (
    .clk(clk), .rst_n(rst_n), .in_tvalid(in_tvalid), .in_tready(in_tready),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .sts(sts), .cmd(cmd)
  );

  prb_dp u_dp (
    .clk(clk), .rst_n(rst_n), .cmd(cmd), .sts(sts), .in_data(in_tdata[96:0]),
    .use_wait(use_wait_r), .def_win(def_win_r), .bound(bound_r), .res(res)
  );
endmodule
